FILE: rtl/core/picl_pkg.sv
// Shared types and constants for the PI current loop PWM block.
`timescale 1ns / 1ps

package picl_pkg;

    // Field and register widths
    localparam int ADC_BITS_DEF = 12;
    localparam int TARGET_W     = 16;
    localparam int GAIN_W       = 28;
    localparam int TIMER_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 28;
    localparam int INTEG_W      = 32;

    // Fixed-point layout
    localparam int FILT_FRAC    = 4;
    localparam int GAIN_SHIFT   = 4;
    localparam int Q24_FRAC     = 24;
    localparam int Q24_ONE      = 1 << Q24_FRAC;

    // Shared multiplier: signed A operand times unsigned B chunk
    localparam int MUL_B_W      = 14;

    // Reset values
    localparam logic [TARGET_W-1:0]       TARGET_RESET = '0;
    localparam logic [GAIN_W-1:0]         KP_RESET     = 28'd134218;
    localparam logic [GAIN_W-1:0]         KI_RESET     = '0;
    localparam logic [TIMER_W-1:0]        PERIOD_RESET = 16'd1023;
    localparam logic signed [INTEG_W-1:0] INTEG_RESET  = 32'sd8388608;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN    = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;

    // Sequencer states, one-hot; bit order matches step_t below
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b1_0000_0000_0000,
        ST_ERR   = 13'b0_1000_0000_0000,
        ST_I_HI  = 13'b0_0100_0000_0000,
        ST_I_LO  = 13'b0_0010_0000_0000,
        ST_I_ACC = 13'b0_0001_0000_0000,
        ST_P_HI  = 13'b0_0000_1000_0000,
        ST_P_LO  = 13'b0_0000_0100_0000,
        ST_P_ACC = 13'b0_0000_0010_0000,
        ST_D_CHK = 13'b0_0000_0001_0000,
        ST_D_HI  = 13'b0_0000_0000_1000,
        ST_D_LO  = 13'b0_0000_0000_0100,
        ST_D_ACC = 13'b0_0000_0000_0010,
        ST_DONE  = 13'b0_0000_0000_0001
    } state_t;

    // Step strobes from sequencer to datapath
    typedef struct packed {
        logic idle;
        logic err;
        logic i_hi;
        logic i_lo;
        logic i_acc;
        logic p_hi;
        logic p_lo;
        logic p_acc;
        logic d_chk;
        logic d_hi;
        logic d_lo;
        logic d_acc;
        logic done;
    } step_t;

endpackage

FILE: rtl/core/picl_mul.sv
// Shared signed-by-unsigned multiplier with a two-chunk product accumulator.
`timescale 1ns / 1ps

module picl_mul #(
    parameter int A_W   = 18,
    parameter int B_W   = picl_pkg::MUL_B_W,
    parameter int ACC_W = A_W + 2 * B_W
) (
    input  logic                    clk,
    input  logic                    mul_en,
    input  logic                    acc_load,
    input  logic signed [A_W-1:0]   a,
    input  logic        [B_W-1:0]   b,
    output logic signed [ACC_W-1:0] sum
);

    localparam int P_W = A_W + B_W;

    logic signed [P_W:0]     prod_full;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_ext;

    // One multiply per cycle while mul_en is high; |a| * b always fits in P_W signed bits
    assign prod_full = a * $signed({1'b0, b});
    assign prod_ext  = {{(ACC_W - P_W){prod_reg[P_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_full[P_W-1:0];
        end
        // High chunk product moves up by one chunk as the low chunk arrives
        if (acc_load)
        begin
            acc_reg <= {prod_reg, {B_W{1'b0}}};
        end
    end

    // Full product: shifted high part plus low part
    assign sum = acc_reg + prod_ext;

endmodule

FILE: rtl/core/picl_ctrl.sv
// Step sequencer for the PI current loop: one sample at a time through the shared multiplier.
`timescale 1ns / 1ps

module picl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                duty_ok,
    input  logic                slot_free,
    output picl_pkg::step_t     step
);

    picl_pkg::state_t state_reg;
    picl_pkg::state_t state_next;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            picl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = picl_pkg::ST_ERR;
                end
            end
            picl_pkg::ST_ERR:   state_next = picl_pkg::ST_I_HI;
            picl_pkg::ST_I_HI:  state_next = picl_pkg::ST_I_LO;
            picl_pkg::ST_I_LO:  state_next = picl_pkg::ST_I_ACC;
            picl_pkg::ST_I_ACC: state_next = picl_pkg::ST_P_HI;
            picl_pkg::ST_P_HI:  state_next = picl_pkg::ST_P_LO;
            picl_pkg::ST_P_LO:  state_next = picl_pkg::ST_P_ACC;
            picl_pkg::ST_P_ACC: state_next = picl_pkg::ST_D_CHK;
            picl_pkg::ST_D_CHK:
            begin
                // Out-of-range duty skips the compare multiply
                state_next = duty_ok ? picl_pkg::ST_D_HI : picl_pkg::ST_DONE;
            end
            picl_pkg::ST_D_HI:  state_next = picl_pkg::ST_D_LO;
            picl_pkg::ST_D_LO:  state_next = picl_pkg::ST_D_ACC;
            picl_pkg::ST_D_ACC: state_next = picl_pkg::ST_DONE;
            picl_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = picl_pkg::ST_IDLE;
                end
            end
            default:            state_next = picl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= picl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One strobe per state bit
    assign step = picl_pkg::step_t'(state_reg);

endmodule

FILE: rtl/core/pi_current_loop_pwm_top.sv
// Top level of the PI current loop: config registers, datapath and output register.
`timescale 1ns / 1ps

// PI current controller with a trapezoidal integrator driving a complementary
// PWM compare pair. Each accepted ADC sample is filtered, compared against
// the current setpoint, run through the PI law in signed Q8.24, and turned into one
// transaction of compare_main, compare_complement and fault_toggle. The block
// works on one sample at a time and skips the duty multiply when the duty
// falls outside [0,1]; it is serial because all six partial products
// (integral, proportional and duty-times-period, two 14-bit chunks each) go
// through one shared multiplier with a registered output. in_stall is low only
// while the sequencer is idle. A finished transaction sits in the output
// register, so the next sample can be accepted while it waits; the sequencer
// holds its result only if the previous one has still not been taken.
// Configuration writes are meant for idle periods and take effect at once.

module pi_current_loop_pwm_top #(
    parameter int ADC_BITS = picl_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ADC_BITS-1:0]                 adc_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [picl_pkg::TIMER_W-1:0]        compare_main,
    output logic [picl_pkg::TIMER_W-1:0]        compare_complement,
    output logic                                fault_toggle,
    input  logic                                cfg_wr_en,
    input  logic [picl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [picl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TARGET_W = picl_pkg::TARGET_W;
    localparam int TIMER_W  = picl_pkg::TIMER_W;
    localparam int GAIN_W   = picl_pkg::GAIN_W;
    localparam int INTEG_W  = picl_pkg::INTEG_W;
    localparam int B_W      = picl_pkg::MUL_B_W;
    localparam int FILT_W   = ADC_BITS + picl_pkg::FILT_FRAC;
    localparam int ERR_W    = ((FILT_W > TARGET_W) ? FILT_W : TARGET_W) + 1;
    localparam int MA_W     = ERR_W + 1;
    localparam int ACC_W    = MA_W + 2 * B_W;
    localparam int TERM_W   = ACC_W - picl_pkg::GAIN_SHIFT;
    localparam int DUTY_W   = ((TERM_W > INTEG_W) ? TERM_W : INTEG_W) + 1;
    localparam int DFR_W    = picl_pkg::Q24_FRAC + 1;
    localparam int DHI_W    = DFR_W - B_W;
    localparam int CMP_LSB  = picl_pkg::Q24_FRAC;

    // Config registers
    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   ki_reg;
    logic [TIMER_W-1:0]  period_reg;

    // Loop state
    logic [FILT_W-1:0]         filt_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [TIMER_W-1:0]        held_reg;
    logic                      out_valid_reg;

    // Per-sample working registers
    logic [ADC_BITS-1:0]       adc_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [MA_W-1:0]    esum_reg;
    logic signed [TERM_W-1:0]  inc_reg;
    logic signed [TERM_W-1:0]  pterm_reg;
    logic [DFR_W-1:0]          duty_reg;
    logic [TIMER_W-1:0]        cmp_reg;
    logic [TIMER_W-1:0]        comp_reg;
    logic                      fault_reg;
    logic [TIMER_W-1:0]        cmp_out_reg;
    logic [TIMER_W-1:0]        comp_out_reg;
    logic                      fault_out_reg;

    picl_pkg::step_t step;

    logic [FILT_W:0]            filt_sum;
    logic [FILT_W-1:0]          filt_next;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [MA_W-1:0]     esum_next;
    logic signed [DUTY_W-1:0]   integ_sum;
    logic [DUTY_W-INTEG_W:0]    integ_top;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [DUTY_W-1:0]   duty;
    logic                       duty_ok;
    logic [TIMER_W-1:0]         cmp_next;
    logic                       slot_free;
    logic signed [MA_W-1:0]     mul_a;
    logic [B_W-1:0]             mul_b;
    logic                       mul_en;
    logic                       acc_load;
    logic signed [ACC_W-1:0]    mul_sum;

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= picl_pkg::TARGET_RESET;
            kp_reg     <= picl_pkg::KP_RESET;
            ki_reg     <= picl_pkg::KI_RESET;
            period_reg <= picl_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                picl_pkg::REG_TARGET: target_reg <= cfg_data[TARGET_W-1:0];
                picl_pkg::REG_KP:     kp_reg     <= cfg_data[GAIN_W-1:0];
                picl_pkg::REG_KI:     ki_reg     <= cfg_data[GAIN_W-1:0];
                picl_pkg::REG_PERIOD: period_reg <= cfg_data[TIMER_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer
    picl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .duty_ok   (duty_ok),
        .slot_free (slot_free),
        .step      (step)
    );

    assign in_stall  = ~step.idle;
    assign slot_free = ~out_valid_reg | ~out_stall;

    // Filter, error and error sum
    assign filt_sum  = {1'b0, adc_reg, {picl_pkg::FILT_FRAC{1'b0}}} + {1'b0, filt_reg};
    assign filt_next = filt_sum[FILT_W:1];
    assign err_next  = $signed({{(ERR_W - TARGET_W){1'b0}}, target_reg})
                     - $signed({{(ERR_W - FILT_W){1'b0}}, filt_next});
    assign esum_next = {err_reg[ERR_W-1], err_reg} + {prev_err_reg[ERR_W-1], prev_err_reg};

    // Multiplier operand select; the error sum is registered during the high chunk
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (step.i_hi || step.i_lo)
        begin
            mul_a = step.i_hi ? esum_next : esum_reg;
            mul_b = step.i_hi ? ki_reg[GAIN_W-1:B_W] : ki_reg[B_W-1:0];
        end
        else if (step.p_hi || step.p_lo)
        begin
            mul_a = {err_reg[ERR_W-1], err_reg};
            mul_b = step.p_hi ? kp_reg[GAIN_W-1:B_W] : kp_reg[B_W-1:0];
        end
        else if (step.d_hi || step.d_lo)
        begin
            mul_a = $signed({{(MA_W - TIMER_W){1'b0}}, period_reg});
            mul_b = step.d_hi ? {{(B_W - DHI_W){1'b0}}, duty_reg[DFR_W-1:B_W]}
                              : duty_reg[B_W-1:0];
        end
        else
        begin
            mul_a = '0;
            mul_b = '0;
        end
    end

    assign mul_en   = step.i_hi | step.i_lo | step.p_hi | step.p_lo | step.d_hi | step.d_lo;
    assign acc_load = step.i_lo | step.p_lo | step.d_lo;

    picl_mul #(
        .A_W   (MA_W),
        .B_W   (B_W),
        .ACC_W (ACC_W)
    ) u_mul (
        .clk      (clk),
        .mul_en   (mul_en),
        .acc_load (acc_load),
        .a        (mul_a),
        .b        (mul_b),
        .sum      (mul_sum)
    );

    // Integrator update with 32-bit saturation
    assign integ_sum = {{(DUTY_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                     + {{(DUTY_W - TERM_W){inc_reg[TERM_W-1]}}, inc_reg};
    assign integ_top = integ_sum[DUTY_W-1:INTEG_W-1];

    always_comb
    begin
        priority if ((&integ_top) || !(|integ_top))
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
        else if (integ_sum[DUTY_W-1])
        begin
            integ_next = picl_pkg::INTEG_MIN;
        end
        else
        begin
            integ_next = picl_pkg::INTEG_MAX;
        end
    end

    // Duty and its [0, 1.0] window test
    assign duty    = {{(DUTY_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                   + {{(DUTY_W - TERM_W){pterm_reg[TERM_W-1]}}, pterm_reg};
    assign duty_ok = ~duty[DUTY_W-1]
                   && (duty[DUTY_W-2:0] <= (DUTY_W - 1)'(picl_pkg::Q24_ONE));

    assign cmp_next = mul_sum[CMP_LSB + TIMER_W - 1:CMP_LSB];

    // Loop state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg      <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= picl_pkg::INTEG_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step.err)
            begin
                filt_reg <= filt_next;
            end
            if (step.p_hi)
            begin
                integ_reg    <= integ_next;
                prev_err_reg <= err_reg;
            end
            if (step.d_acc)
            begin
                held_reg <= cmp_next;
            end
            if (step.done && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        if (step.idle && in_valid)
        begin
            adc_reg <= adc_sample;
        end
        if (step.err)
        begin
            err_reg <= err_next;
        end
        if (step.i_hi)
        begin
            esum_reg <= esum_next;
        end
        if (step.i_acc)
        begin
            inc_reg <= mul_sum[ACC_W-1:picl_pkg::GAIN_SHIFT];
        end
        if (step.p_acc)
        begin
            pterm_reg <= mul_sum[ACC_W-1:picl_pkg::GAIN_SHIFT];
        end
        if (step.d_chk)
        begin
            duty_reg  <= duty[DFR_W-1:0];
            // Hold previous compare on an out-of-window duty
            cmp_reg   <= held_reg;
            comp_reg  <= (held_reg > period_reg) ? '0 : period_reg - held_reg;
            fault_reg <= ~duty_ok;
        end
        if (step.d_acc)
        begin
            cmp_reg  <= cmp_next;
            comp_reg <= period_reg - cmp_next;
        end
        if (step.done && slot_free)
        begin
            cmp_out_reg   <= cmp_reg;
            comp_out_reg  <= comp_reg;
            fault_out_reg <= fault_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign compare_main       = cmp_out_reg;
    assign compare_complement = comp_out_reg;
    assign fault_toggle       = fault_out_reg;

endmodule

FILE: tb/pi_loop_checker.sv
// Watches the PI current loop channels, predicts each PWM result and compares it.
`timescale 1ns / 1ps

module pi_loop_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic [picl_pkg::ADC_BITS_DEF-1:0]       adc_sample,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [picl_pkg::TIMER_W-1:0]            compare_main,
    input  logic [picl_pkg::TIMER_W-1:0]            compare_complement,
    input  logic                                    fault_toggle,
    input  logic                                    cfg_wr_en,
    input  logic [picl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [picl_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                      fail_count,
    output int                                      pending_results,
    output logic signed [picl_pkg::INTEG_W-1:0]     integ_q24,
    output logic [picl_pkg::TARGET_W-1:0]           filt_q4,
    output logic signed [picl_pkg::TARGET_W:0]      last_err
);

    localparam int ADC_BITS_DEF = picl_pkg::ADC_BITS_DEF;
    localparam int TARGET_W     = picl_pkg::TARGET_W;
    localparam int GAIN_W       = picl_pkg::GAIN_W;
    localparam int TIMER_W      = picl_pkg::TIMER_W;
    localparam int INTEG_W      = picl_pkg::INTEG_W;
    localparam int GAIN_SHIFT   = picl_pkg::GAIN_SHIFT;
    localparam int Q24_FRAC     = picl_pkg::Q24_FRAC;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TIMER_W-1:0] cmp_main;
        logic [TIMER_W-1:0] cmp_comp;
        logic               fault;
    } pwm_result_t;

    // Shadow copy of the configuration registers
    logic [TARGET_W-1:0] target_q4;
    logic [GAIN_W-1:0]   kp_gain;
    logic [GAIN_W-1:0]   ki_gain;
    logic [TIMER_W-1:0]  period;

    // Loop state besides the values exported to the top
    logic [TIMER_W-1:0]  held_cmp;

    pwm_result_t pwm_expected[$];
    pwm_result_t want;
    int          result_idx;

    // One control-loop update: filter, error, integrator, duty, compare pair
    function automatic pwm_result_t advance_loop(input logic [ADC_BITS_DEF-1:0] adc);
        longint      err;
        longint      acc;
        longint      duty;
        longint      scaled;
        pwm_result_t res;
        filt_q4 = TARGET_W'((longint'(adc) * 16 + longint'(filt_q4)) >>> 1);
        err = longint'(target_q4) - longint'(filt_q4);
        // trapezoidal step, Q.28 product floored back to Q.24
        acc = longint'(integ_q24)
            + ((longint'(ki_gain) * (err + longint'(last_err))) >>> GAIN_SHIFT);
        if (acc > longint'(picl_pkg::INTEG_MAX))
            acc = longint'(picl_pkg::INTEG_MAX);
        else if (acc < longint'(picl_pkg::INTEG_MIN))
            acc = longint'(picl_pkg::INTEG_MIN);
        integ_q24 = INTEG_W'(acc);
        last_err = (TARGET_W+1)'(err);
        duty = longint'(integ_q24) + ((longint'(kp_gain) * err) >>> GAIN_SHIFT);
        if (duty >= 0 && duty <= longint'(picl_pkg::Q24_ONE))
        begin
            scaled = (duty * longint'(period)) >>> Q24_FRAC;
            held_cmp = TIMER_W'(scaled);
            res.cmp_main = held_cmp;
            res.cmp_comp = period - held_cmp;
            res.fault = 1'b0;
        end
        else
        begin
            // duty out of range: hold the last compare, flag the fault
            res.cmp_main = held_cmp;
            res.cmp_comp = (held_cmp > period) ? '0 : period - held_cmp;
            res.fault = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_q4 = picl_pkg::TARGET_RESET;
            kp_gain = picl_pkg::KP_RESET;
            ki_gain = picl_pkg::KI_RESET;
            period = picl_pkg::PERIOD_RESET;
            filt_q4 = '0;
            last_err = '0;
            integ_q24 = picl_pkg::INTEG_RESET;
            held_cmp = '0;
            pwm_expected.delete();
            pending_results = 0;
            fail_count = 0;
            result_idx = 0;
        end
        else
        begin
            // register writes; unknown indexes are dropped
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    picl_pkg::REG_TARGET: target_q4 = cfg_data[TARGET_W-1:0];
                    picl_pkg::REG_KP:     kp_gain = cfg_data[GAIN_W-1:0];
                    picl_pkg::REG_KI:     ki_gain = cfg_data[GAIN_W-1:0];
                    picl_pkg::REG_PERIOD: period = cfg_data[TIMER_W-1:0];
                    default:    ;
                endcase
            end

            if (in_valid && !in_stall)
                pwm_expected.push_back(advance_loop(adc_sample));

            // result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pwm_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d unexpected: main %0d comp %0d fault %0b",
                                 result_idx, compare_main, compare_complement,
                                 fault_toggle);
                end
                else
                begin
                    want = pwm_expected.pop_front();
                    if (compare_main !== want.cmp_main
                        || compare_complement !== want.cmp_comp
                        || fault_toggle !== want.fault)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("result %0d: main exp %0d got %0d, comp exp %0d got %0d, %s",
                                     result_idx, want.cmp_main, compare_main,
                                     want.cmp_comp, compare_complement,
                                     $sformatf("fault exp %0b got %0b",
                                               want.fault, fault_toggle));
                    end
                end
                result_idx++;
            end
            pending_results = pwm_expected.size();
        end
    end

endmodule

FILE: tb/pi_current_loop_pwm_top_tb.sv
// Stimulus and verdict for the PI current loop PWM block.
`timescale 1ns / 1ps

module pi_current_loop_pwm_top_tb;

    localparam int ADC_BITS_DEF    = picl_pkg::ADC_BITS_DEF;
    localparam int TIMER_W         = picl_pkg::TIMER_W;
    localparam int CFG_IDX_W       = picl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = picl_pkg::CFG_DATA_W;
    localparam int INTEG_W         = picl_pkg::INTEG_W;
    localparam int TARGET_W        = picl_pkg::TARGET_W;
    localparam int GAIN_W          = picl_pkg::GAIN_W;
    localparam int FILT_FRAC       = picl_pkg::FILT_FRAC;

    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE          = 20;
    localparam int DRAIN           = 40;
    localparam int LONG_HOLD       = 150;
    localparam int PRESSURE_PHASE  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [GAIN_W-1:0]    GAIN_MAX = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [ADC_BITS_DEF-1:0] adc_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [TIMER_W-1:0]     compare_main;
    logic [TIMER_W-1:0]     compare_complement;
    logic                   fault_toggle;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                         fail_count;
    int                         pending_results;
    logic signed [INTEG_W-1:0]  chk_integ;
    logic [TARGET_W-1:0]        chk_filt;
    logic signed [TARGET_W:0]   chk_err;

    bit tail_mode;
    bit long_hold_req;

    pi_current_loop_pwm_top uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .adc_sample         (adc_sample),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .compare_main       (compare_main),
        .compare_complement (compare_complement),
        .fault_toggle       (fault_toggle),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    pi_loop_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .adc_sample         (adc_sample),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .compare_main       (compare_main),
        .compare_complement (compare_complement),
        .fault_toggle       (fault_toggle),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending_results    (pending_results),
        .integ_q24          (chk_integ),
        .filt_q4            (chk_filt),
        .last_err           (chk_err)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("pi_current_loop_pwm_top_tb NOT OK");
        $finish;
    end

    // Register write, one cycle of enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // One sample transaction, optionally preceded by a random gap
    task automatic send_sample(input logic [ADC_BITS_DEF-1:0] sample, input bit gaps);
        int n;
        if (gaps && !tail_mode && $urandom_range(0, 3) == 0)
        begin
            n = int'($urandom_range(1, 16));
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= sample;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop sending and let every predicted result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Drive the integrator near a chosen duty with two samples: the first sets
    // a known error history, the second applies a gain sized for the jump
    task automatic recenter(input longint goal);
        logic [TARGET_W-1:0]     tgt;
        logic [ADC_BITS_DEF-1:0] sample;
        longint                  shortfall;
        longint                  f_next;
        longint                  err_sum;
        longint                  gain;
        wait_idle();
        shortfall = goal - longint'(chk_integ);
        if (shortfall >= 0)
        begin
            tgt = '1;
            sample = '0;
        end
        else
        begin
            tgt = '0;
            sample = '1;
        end
        write_reg(picl_pkg::REG_KP, '0);
        write_reg(picl_pkg::REG_KI, '0);
        write_reg(picl_pkg::REG_TARGET, {12'($urandom), tgt});
        send_sample(sample, 1'b0);
        wait_idle();
        f_next = (longint'(sample) * 16 + longint'(chk_filt)) >>> 1;
        err_sum = longint'(tgt) - f_next + longint'(chk_err);
        gain = (shortfall * 16) / err_sum;
        if (gain < 0)
            gain = 0;
        if (gain > longint'(GAIN_MAX))
            gain = longint'(GAIN_MAX);
        write_reg(picl_pkg::REG_KI, GAIN_W'(gain));
        send_sample(sample, 1'b0);
    endtask

    // Result side: random stall bursts, calm windows, one long hold-off
    initial
    begin
        int n;
        int recv_cyc;
        recv_cyc = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            recv_cyc++;
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (tail_mode || (recv_cyc / 300) % 4 == 3)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                n = int'($urandom_range(1, 16));
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Main stimulus
    initial
    begin
        logic [TARGET_W-1:0]     tgt;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       ki;
        logic [TIMER_W-1:0]      per;
        logic [ADC_BITS_DEF-1:0] sample;
        int                      noise;
        int                      level;
        bit                      wild;
        bit                      gaps;

        in_valid = 1'b0;
        adc_sample = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tail_mode = 1'b0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero error, full scale, bit patterns
        send_sample(12'h000, 1'b1);
        send_sample(12'hFFF, 1'b1);
        send_sample(12'hAAA, 1'b1);
        send_sample(12'h555, 1'b1);
        send_sample(12'h800, 1'b1);

        // Maximum gains and target: integrator saturates high; the extra
        // bits of the 16-bit registers and the unused index are dropped
        wait_idle();
        write_reg(picl_pkg::REG_TARGET, {12'hABC, 16'hFFFF});
        write_reg(picl_pkg::REG_KP, GAIN_MAX);
        write_reg(picl_pkg::REG_KI, GAIN_MAX);
        write_reg(picl_pkg::REG_PERIOD, {12'h5A5, 16'hFFFF});
        write_reg(REG_NONE, 28'h0000123);
        send_sample(12'h000, 1'b0);
        send_sample(12'hFFF, 1'b0);

        // Zero target, large samples: integrator saturates low
        wait_idle();
        write_reg(picl_pkg::REG_TARGET, '0);
        write_reg(picl_pkg::REG_KP, '0);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'hFFF, 1'b0);

        // Back to half duty, then a zero and a unit period
        recenter(longint'(picl_pkg::Q24_ONE / 2));
        wait_idle();
        write_reg(picl_pkg::REG_KP, '0);
        write_reg(picl_pkg::REG_KI, '0);
        write_reg(picl_pkg::REG_PERIOD, {12'hFFF, 16'h0000});
        send_sample(12'h7FF, 1'b0);
        send_sample(12'h800, 1'b0);
        wait_idle();
        write_reg(picl_pkg::REG_PERIOD, 28'd1);
        send_sample(12'h001, 1'b0);
        send_sample(12'hFFE, 1'b0);

        // Held compare larger than a freshly shortened period
        wait_idle();
        write_reg(picl_pkg::REG_PERIOD, 28'hFFFF);
        send_sample(12'h800, 1'b0);
        wait_idle();
        write_reg(picl_pkg::REG_PERIOD, 28'd100);
        write_reg(picl_pkg::REG_KP, GAIN_MAX);
        write_reg(picl_pkg::REG_TARGET, 28'hFFFF);
        send_sample(12'h000, 1'b0);

        // Random phases: samples around the setpoint with modest gains, and
        // every fifth phase with wild gains and samples
        for (int p = 0; p < PHASES; p++)
        begin
            tail_mode = (p >= PHASES - 2);
            wild = (p % 5 == 4);
            recenter(longint'($urandom_range(4_000_000, 12_000_000)));
            wait_idle();
            if (p == 1)
                tgt = '0;
            else if (p == 2)
                tgt = '1;
            else
                tgt = TARGET_W'($urandom_range(0, 65535));
            if (wild)
            begin
                kp = GAIN_W'($urandom);
                ki = GAIN_W'($urandom);
                noise = 4095;
            end
            else
            begin
                kp = GAIN_W'($urandom_range(0, 1 << 17));
                ki = GAIN_W'($urandom_range(0, 200));
                noise = int'($urandom_range(1, 64));
            end
            case ($urandom_range(0, 5))
                0:       per = '1;
                1:       per = 16'd1;
                2:       per = TIMER_W'($urandom_range(2, 255));
                default: per = TIMER_W'($urandom_range(1, 65535));
            endcase
            write_reg(picl_pkg::REG_TARGET, {12'($urandom), tgt});
            write_reg(picl_pkg::REG_KP, kp);
            write_reg(picl_pkg::REG_KI, ki);
            write_reg(picl_pkg::REG_PERIOD, {12'($urandom), per});

            // back-to-back samples against a stalled result side
            if (p == PRESSURE_PHASE)
                long_hold_req = 1'b1;
            gaps = (p % 3 != 2) && (p != PRESSURE_PHASE);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (wild || $urandom_range(0, 9) == 0)
                    sample = ADC_BITS_DEF'($urandom);
                else
                begin
                    level = int'(tgt >> FILT_FRAC)
                          + int'($urandom_range(0, 2 * noise)) - noise;
                    if (level < 0)
                        level = 0;
                    if (level > 4095)
                        level = 4095;
                    sample = ADC_BITS_DEF'(level);
                end
                send_sample(sample, gaps);
            end
        end

        // Drain and verdict
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("pi_current_loop_pwm_top_tb OK");
        else
            $display("pi_current_loop_pwm_top_tb NOT OK");
        $finish;
    end

endmodule
